// ===== rtl/brwr_pkg.sv =====
`default_nettype none
package brwr_pkg;

    // Default number of slots in the ring
    localparam int LEN_DEF = 16;

    // Packed stream widths (whole bytes)
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    // Operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_REDUCE = 2'd2;

    // Reduction kinds
    localparam logic [1:0] RED_AND = 2'd0;
    localparam logic [1:0] RED_OR  = 2'd1;
    localparam logic [1:0] RED_XOR = 2'd2;
    localparam logic [1:0] RED_MAJ = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic execute;   // apply the latched item to the ring
    } dp_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/brwr_ctrl.sv =====
`default_nettype none
module brwr_ctrl
    import brwr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output dp_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/brwr_datapath.sv =====
`default_nettype none
module brwr_datapath
    import brwr_pkg::*;
#(
    parameter int LEN = LEN_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire dp_cmd_t    cmd,
    input  wire logic [1:0] operation,
    input  wire logic       write_bit,
    input  wire logic [1:0] reduce_op,
    input  wire logic       cfg_we,
    input  wire logic       cfg_bit,
    output logic            result_bit,
    output logic            full_flag,
    output logic            empty_flag
);

    localparam int IDX_W = (LEN > 1) ? $clog2(LEN) : 1;
    localparam int CNT_W = $clog2(LEN + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LEN - 1);
    localparam logic [CNT_W-1:0] CNT_ALL  = CNT_W'(LEN);
    localparam logic [CNT_W-1:0] CNT_HALF = CNT_W'(LEN / 2);

    logic [LEN-1:0]   store_reg, store_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;   // ones over all slots
    logic             overwrite_reg;

    // Latched item
    logic [1:0] op_reg;
    logic       bit_reg;
    logic [1:0] kind_reg;

    // Result holding register
    logic result_reg, result_next;
    logic full_reg, full_next;
    logic empty_reg, empty_next;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    logic is_full, ring_empty, old_bit, reduced;

    // Ring update for one operation
    always_comb begin
        is_full     = (next_slot(tail_reg) == head_reg);
        ring_empty  = (head_reg == tail_reg);
        old_bit     = store_reg[tail_reg];
        store_next  = store_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        result_next = 1'b0;

        // Reductions come from the running ones count
        case (kind_reg)
            RED_AND: reduced = (count_reg == CNT_ALL);
            RED_OR:  reduced = (count_reg != '0);
            RED_XOR: reduced = count_reg[0];
            default: reduced = (count_reg > CNT_HALF);
        endcase

        case (op_reg)
            OP_WRITE: begin
                if (overwrite_reg || !is_full) begin
                    if (is_full) begin
                        head_next = next_slot(head_reg);
                    end
                    store_next[tail_reg] = bit_reg;
                    tail_next = next_slot(tail_reg);
                    if (bit_reg && !old_bit) begin
                        count_next = count_reg + 1'b1;
                    end else if (!bit_reg && old_bit) begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            OP_READ: begin
                if (!ring_empty) begin
                    result_next = store_reg[head_reg];
                    head_next   = next_slot(head_reg);
                end
            end
            OP_REDUCE: begin
                result_next = (!overwrite_reg && ring_empty) ? 1'b0 : reduced;
            end
            default: begin
            end
        endcase

        full_next  = (next_slot(tail_next) == head_next);
        empty_next = (head_next == tail_next);
    end

    // Ring state and mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            overwrite_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                overwrite_reg <= cfg_bit;
            end
            if (cmd.execute) begin
                store_reg <= store_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= operation;
            bit_reg  <= write_bit;
            kind_reg <= reduce_op;
        end
        if (cmd.execute) begin
            result_reg <= result_next;
            full_reg   <= full_next;
            empty_reg  <= empty_next;
        end
    end

    assign result_bit = result_reg;
    assign full_flag  = full_reg;
    assign empty_flag = empty_reg;

endmodule
`default_nettype wire

// ===== rtl/bit_ring_window_reducer_unit.sv =====
// Ring of LEN single-bit samples with a reducer over all slots.
// Input stream s_*: one transfer carries operation, write_bit and reduce_op.
// Result stream m_*: exactly one transfer per input item with result_bit,
//   full_flag (LEN-1 entries held) and empty_flag.
// Config channel cfg_*: one write sets overwrite_mode; cfg_ready is always
//   high. Write it only while no item is in flight.
// After the input transfer the controller passes through execute, and
//   m_tvalid rises in respond, where the result transfer can complete.
// The controller walks idle, execute and respond, one item at a time, so
//   it takes no new item until the result transfer completes.
// Reductions use a running count of ones kept beside the ring, so a reduce
//   costs no more than a write or read.
// Reset (aresetn low, synchronous) clears every slot, both indices, the
//   count and overwrite_mode, and drops any pending result.
// A stalled receiver holds the result and keeps s_tready low until the
//   result transfer completes.
`default_nettype none
module bit_ring_window_reducer_unit
    import brwr_pkg::*;
#(
    parameter int LEN = LEN_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [1:0] operation, [2] write_bit, [4:3] reduce_op, [7:5] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] result_bit, [1] full_flag, [2] empty_flag, [7:3] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [0:0]           cfg_data
);

    dp_cmd_t cmd;
    logic    result_bit, full_flag, empty_flag;

    assign cfg_ready = 1'b1;

    brwr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    brwr_datapath #(
        .LEN (LEN)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .operation  (s_tdata[1:0]),
        .write_bit  (s_tdata[2]),
        .reduce_op  (s_tdata[4:3]),
        .cfg_we     (cfg_valid),
        .cfg_bit    (cfg_data[0]),
        .result_bit (result_bit),
        .full_flag  (full_flag),
        .empty_flag (empty_flag)
    );

    // Pack result fields, low bit first
    assign m_tdata = {{(M_TDATA_W-3){1'b0}}, empty_flag, full_flag, result_bit};

endmodule
`default_nettype wire
